@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property check, disabled while reset is asserted.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property check failed");

// Condition that must never be true out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ hdl/nv21r90_pkg.sv @@
// Shared types, constants and functions of the NV21 rotate-and-convert block.
`timescale 1ns / 1ps

package nv21r90_pkg;

    // Geometry
    localparam int unsigned MAX_WIDTH_DEF  = 512;
    localparam int unsigned MAX_HEIGHT_DEF = 512;
    localparam int unsigned DIM_W          = 10;
    localparam logic [DIM_W-1:0] FRAME_DIM_RST = 10'd512;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // Conversion arithmetic
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned ARGB_W = 32;
    localparam int unsigned PROD_W = 21;
    localparam int unsigned SUM_W  = 22;
    localparam int unsigned CH_W   = 18;
    localparam logic signed [PROD_W-1:0] K_Y   = 21'sd1192;
    localparam logic signed [PROD_W-1:0] K_R_V = 21'sd1634;
    localparam logic signed [PROD_W-1:0] K_G_V = 21'sd833;
    localparam logic signed [PROD_W-1:0] K_G_U = 21'sd400;
    localparam logic signed [PROD_W-1:0] K_B_U = 21'sd2066;
    localparam logic [BYTE_W-1:0] LUMA_OFS   = 8'd16;
    localparam logic signed [BYTE_W:0] CHROMA_OFS = 9'sd128;
    localparam logic signed [SUM_W-1:0] CH_MAX = 22'sd262143;
    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // Request actions
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    typedef struct packed {
        logic              action;
        logic [BYTE_W-1:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [ARGB_W-1:0] argb;
        logic              last_pixel;
        logic              not_ready;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_ADDR,
        S_RD0,
        S_RD1,
        S_MUL,
        S_SUM,
        S_NRDY
    } t_state;

    typedef struct packed {
        logic load;
        logic fetch;
        logic div_start;
        logic div_take;
        logic addr;
        logic rd1;
        logic mul;
        logic emit_pix;
        logic emit_nrdy;
    } t_dp_cmd;

    typedef struct packed {
        logic ready;
        logic need_div;
        logic div_done;
        logic out_free;
    } t_dp_status;

    // Even dimension, saturated to 2..max (max rounded down to even).
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned max_dim);
        logic [DIM_W-1:0] d;
        int unsigned      m;
        d = {v[DIM_W-1:1], 1'b0};
        m = max_dim & ~32'd1;
        if (d < DIM_W'(2)) d = DIM_W'(2);
        if (32'(d) > m) d = DIM_W'(m);
        return d;
    endfunction

    function automatic logic [CH_W-1:0] clamp_ch(input logic signed [SUM_W-1:0] s);
        logic [CH_W-1:0] c;
        if (s < 0) c = '0;
        else if (s > CH_MAX) c = CH_W'(CH_MAX);
        else c = CH_W'(s);
        return c;
    endfunction

endpackage

@@ hdl/nv21_rotate90_to_argb.sv @@
// Load: one byte per cycle while no fetch is busy, stored in the cycle it is taken, no result.
// Fetch: steps address, luma and V read, U read, multiply, then sum, where the result is
//   registered; an output stall holds the sum step and input stalls until the fetch ends.
// After a height change mid-frame the first fetch adds a row/column divide of
//   the pixel index by the height. A fetch before the frame is loaded gives a not-ready result.
// Synchronous active-low reset clears counters and flags and sets 512 x 512; memory is not cleared.
`timescale 1ns / 1ps

module nv21_rotate90_to_argb #(
    parameter int unsigned MAX_WIDTH  = nv21r90_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = nv21r90_pkg::MAX_HEIGHT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [nv21r90_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [nv21r90_pkg::DIM_W-1:0]      i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  nv21r90_pkg::t_in_item              i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output nv21r90_pkg::t_out_item             o_out_data
);

    nv21r90_pkg::t_dp_cmd    cmd;
    nv21r90_pkg::t_dp_status status;

    nv21r90_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_data.action),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    nv21r90_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_data_byte (i_in_data.data_byte),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ hdl/nv21r90_div.sv @@
// Restoring divider, one quotient bit per cycle, for pixel index to row/column.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nv21r90_div #(
    parameter int unsigned DVD_W = 19
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [DVD_W-1:0]               i_dividend,
    input  logic [nv21r90_pkg::DIM_W-1:0]  i_divisor,
    output logic                           o_done,
    output logic [DVD_W-1:0]               o_quot,
    output logic [nv21r90_pkg::DIM_W-1:0]  o_rem
);

    localparam int unsigned DW     = nv21r90_pkg::DIM_W;
    localparam int unsigned CNT_BW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  r_quo;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_div;
    logic [CNT_BW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DW:0]       shifted;
    logic              qbit;
    logic [DW:0]       diff;

    always_comb begin
        shifted = {r_rem, r_quo[DVD_W-1]};
        qbit    = (shifted >= {1'b0, r_div});
        diff    = shifted - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BW'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_BW'(1);
                if (r_cnt == CNT_BW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], qbit};
            r_rem <= qbit ? DW'(diff) : DW'(shifted);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

    `ASSERT_PROP(a_rem_below_div, i_clk, i_rst_n, r_done |-> (r_rem < r_div))
    `ASSERT_PROP(a_start_busy, i_clk, i_rst_n, i_start |=> r_busy)
    `ASSERT_NEVER(a_done_while_busy, i_clk, i_rst_n, r_done && r_busy)

endmodule

@@ hdl/nv21r90_dp.sv @@
// Datapath: frame store, geometry, counters, address math and color conversion.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nv21r90_dp #(
    parameter int unsigned MAX_WIDTH  = nv21r90_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = nv21r90_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [nv21r90_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [nv21r90_pkg::DIM_W-1:0]       i_cfg_wdata,
    input  logic [nv21r90_pkg::BYTE_W-1:0]      i_data_byte,
    input  nv21r90_pkg::t_dp_cmd                i_cmd,
    output nv21r90_pkg::t_dp_status             o_status,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output nv21r90_pkg::t_out_item              o_out_data
);

    localparam int unsigned DW          = nv21r90_pkg::DIM_W;
    localparam int unsigned BW          = nv21r90_pkg::BYTE_W;
    localparam int unsigned PW          = nv21r90_pkg::PROD_W;
    localparam int unsigned SW          = nv21r90_pkg::SUM_W;
    localparam int unsigned CW          = nv21r90_pkg::CH_W;
    localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * 3 / 2;
    localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int unsigned PIX_W       = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam logic [DW-1:0] RST_W =
        nv21r90_pkg::eff_dim(nv21r90_pkg::FRAME_DIM_RST, MAX_WIDTH);
    localparam logic [DW-1:0] RST_H =
        nv21r90_pkg::eff_dim(nv21r90_pkg::FRAME_DIM_RST, MAX_HEIGHT);
    localparam int unsigned RST_NPIX   = int'(RST_W) * int'(RST_H);
    localparam int unsigned RST_NBYTES = RST_NPIX * 3 / 2;

    // Geometry
    logic [DW-1:0]    r_w;
    logic [DW-1:0]    r_h;
    logic [PIX_W-1:0] r_npix;
    logic [CNT_W-1:0] r_nbytes;

    // Frame progress
    logic [CNT_W-1:0] r_bytes;
    logic             r_complete;
    logic [PIX_W-1:0] r_p;
    logic [DW-1:0]    r_i;
    logic [DW-1:0]    r_j;
    logic [DW-1:0]    r_hq;

    // Per-fetch pipeline
    logic              r_last;
    logic [DW-1:0]     r_ci;
    logic [DW-1:0]     r_cj;
    logic [ADDR_W-1:0] r_ya;
    logic [ADDR_W-1:0] r_ca;
    logic [BW-1:0]     r_mem [STORE_DEPTH];
    logic [BW-1:0]     r_qa;
    logic [BW-1:0]     r_qb;
    logic [BW-1:0]     r_v;
    logic signed [PW-1:0] r_py;
    logic signed [PW-1:0] r_prv;
    logic signed [PW-1:0] r_pgv;
    logic signed [PW-1:0] r_pgu;
    logic signed [PW-1:0] r_pbu;
    logic                    r_out_valid;
    nv21r90_pkg::t_out_item  r_out;

    logic [DW-1:0]     new_w;
    logic [DW-1:0]     new_h;
    logic [DW-1:0]     op_w;
    logic [DW-1:0]     op_h;
    logic [DW:0]       op_h15;
    logic [2*DW-1:0]   npix_prod;
    logic [2*DW:0]     nb_prod;

    logic              ready;
    logic              last;
    logic              need_div;
    logic              out_free;
    logic              mem_we;
    logic [CNT_W-1:0]  bytes_inc;

    logic              div_done;
    logic [PIX_W-1:0]  div_quot;
    logic [DW-1:0]     div_rem;

    logic [DW-1:0]     yrow;
    logic [DW-1:0]     crow;
    logic [2*DW-1:0]   ya_prod;
    logic [2*DW-1:0]   ca_prod;
    logic [ADDR_W-1:0] ya_sum;
    logic [CNT_W-1:0]  ca_sum;
    logic [ADDR_W-1:0] rb_addr;

    logic [BW-1:0]        yv;
    logic signed [BW:0]   v9;
    logic signed [BW:0]   u9;
    logic signed [PW-1:0] ys;
    logic signed [PW-1:0] vs;
    logic signed [PW-1:0] us;
    logic signed [SW-1:0] sr;
    logic signed [SW-1:0] sg;
    logic signed [SW-1:0] sb;
    logic [CW-1:0]        rc;
    logic [CW-1:0]        gc;
    logic [CW-1:0]        bc;

    // Geometry products are formed at write time so they line up with the registers.
    always_comb begin
        new_w     = nv21r90_pkg::eff_dim(i_cfg_wdata, MAX_WIDTH);
        new_h     = nv21r90_pkg::eff_dim(i_cfg_wdata, MAX_HEIGHT);
        op_w      = (i_cfg_idx == nv21r90_pkg::CFG_FRAME_WIDTH)  ? new_w : r_w;
        op_h      = (i_cfg_idx == nv21r90_pkg::CFG_FRAME_HEIGHT) ? new_h : r_h;
        op_h15    = {1'b0, op_h} + {2'b00, op_h[DW-1:1]};
        npix_prod = op_w * op_h;
        nb_prod   = op_w * op_h15;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w      <= RST_W;
            r_h      <= RST_H;
            r_npix   <= PIX_W'(RST_NPIX);
            r_nbytes <= CNT_W'(RST_NBYTES);
        end else if (i_cfg_we) begin
            r_w      <= op_w;
            r_h      <= op_h;
            r_npix   <= PIX_W'(npix_prod);
            r_nbytes <= CNT_W'(nb_prod);
        end
    end

    always_comb begin
        ready     = r_complete || (r_bytes >= r_nbytes);
        last      = (r_p >= (r_npix - PIX_W'(1)));
        need_div  = !last && (r_p != '0) && (r_hq != r_h);
        out_free  = !r_out_valid || !i_out_stall;
        mem_we    = i_cmd.load && !ready;
        bytes_inc = r_bytes + CNT_W'(1);
    end

    assign o_status = '{ready: ready, need_div: need_div, div_done: div_done,
                        out_free: out_free};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes     <= '0;
            r_complete  <= 1'b0;
            r_p         <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_hq        <= RST_H;
            r_out_valid <= 1'b0;
        end else begin
            if (mem_we) begin
                r_bytes <= bytes_inc;
                if (bytes_inc >= r_nbytes) r_complete <= 1'b1;
            end
            if (i_cmd.emit_pix) begin
                r_hq <= r_h;
                if (r_last) begin
                    // rearm for the next frame
                    r_p        <= '0;
                    r_bytes    <= '0;
                    r_complete <= 1'b0;
                    r_i        <= '0;
                    r_j        <= '0;
                end else begin
                    r_p <= r_p + PIX_W'(1);
                    if (r_ci == r_h - DW'(1)) begin
                        r_i <= '0;
                        r_j <= r_cj + DW'(1);
                    end else begin
                        r_i <= r_ci + DW'(1);
                        r_j <= r_cj;
                    end
                end
            end
            if (i_cmd.emit_pix || i_cmd.emit_nrdy) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    nv21r90_div #(
        .DVD_W (PIX_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_p),
        .i_divisor  (r_h),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Source addresses of luma and of the VU pair
    always_comb begin
        yrow    = r_h - DW'(1) - r_ci;
        crow    = {1'b0, r_h[DW-1:1]} - DW'(1) - {1'b0, r_ci[DW-1:1]};
        ya_prod = yrow * r_w;
        ca_prod = crow * r_w;
        ya_sum  = ADDR_W'(ya_prod) + ADDR_W'(r_cj);
        ca_sum  = CNT_W'(r_npix) + CNT_W'(ca_prod) + CNT_W'({r_cj[DW-1:1], 1'b0});
        rb_addr = i_cmd.rd1 ? ADDR_W'(r_ca + ADDR_W'(1)) : r_ca;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[r_bytes[ADDR_W-1:0]] <= i_data_byte;
        r_qa <= r_mem[r_ya];
        r_qb <= r_mem[rb_addr];
    end

    always_comb begin
        yv = (r_qa < nv21r90_pkg::LUMA_OFS) ? '0 : r_qa - nv21r90_pkg::LUMA_OFS;
        v9 = $signed({1'b0, r_v}) - nv21r90_pkg::CHROMA_OFS;
        u9 = $signed({1'b0, r_qb}) - nv21r90_pkg::CHROMA_OFS;
        ys = $signed(PW'(yv));
        vs = PW'(v9);
        us = PW'(u9);
        sr = SW'(r_py) + SW'(r_prv);
        sg = SW'(r_py) - SW'(r_pgv) - SW'(r_pgu);
        sb = SW'(r_py) + SW'(r_pbu);
        rc = nv21r90_pkg::clamp_ch(sr);
        gc = nv21r90_pkg::clamp_ch(sg);
        bc = nv21r90_pkg::clamp_ch(sb);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_last <= last;
            r_ci   <= last ? r_h - DW'(1) : r_i;
            r_cj   <= last ? r_w - DW'(1) : r_j;
        end else if (i_cmd.div_take) begin
            r_ci <= div_rem;
            r_cj <= DW'(div_quot);
        end
        if (i_cmd.addr) begin
            r_ya <= ya_sum;
            r_ca <= ADDR_W'(ca_sum);
        end
        // hold V while port B moves on to U
        if (i_cmd.rd1) r_v <= r_qb;
        if (i_cmd.mul) begin
            r_py  <= ys * nv21r90_pkg::K_Y;
            r_prv <= vs * nv21r90_pkg::K_R_V;
            r_pgv <= vs * nv21r90_pkg::K_G_V;
            r_pgu <= us * nv21r90_pkg::K_G_U;
            r_pbu <= us * nv21r90_pkg::K_B_U;
        end
        if (i_cmd.emit_pix) begin
            r_out <= '{argb: {nv21r90_pkg::ALPHA_OPAQUE, rc[CW-1 -: BW], gc[CW-1 -: BW],
                              bc[CW-1 -: BW]},
                       last_pixel: r_last, not_ready: 1'b0};
        end else if (i_cmd.emit_nrdy) begin
            r_out <= '{argb: '0, last_pixel: 1'b0, not_ready: 1'b1};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_PROP(a_rearm, i_clk, i_rst_n,
        (i_cmd.emit_pix && r_last) |=> (r_bytes == '0 && !r_complete && r_p == '0))
    `ASSERT_PROP(a_emit_valid, i_clk, i_rst_n,
        (i_cmd.emit_pix || i_cmd.emit_nrdy) |=> r_out_valid)
    `ASSERT_PROP(a_load_ignored, i_clk, i_rst_n,
        (i_cmd.load && ready && !i_cfg_we) |=> $stable(r_bytes))

endmodule

@@ hdl/nv21r90_ctrl.sv @@
// Controller state machine: sequences loads and the steps of each pixel fetch.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nv21r90_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_action,
    input  nv21r90_pkg::t_dp_status  i_status,
    output nv21r90_pkg::t_dp_cmd     o_cmd,
    output logic                     o_in_stall
);

    nv21r90_pkg::t_state r_state;
    nv21r90_pkg::t_state n_state;

    logic take;

    assign take = i_in_valid && (r_state == nv21r90_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nv21r90_pkg::S_IDLE: begin
                if (take && i_action == nv21r90_pkg::ACT_FETCH) begin
                    if (!i_status.ready) n_state = nv21r90_pkg::S_NRDY;
                    else if (i_status.need_div) n_state = nv21r90_pkg::S_DIV;
                    else n_state = nv21r90_pkg::S_ADDR;
                end
            end
            nv21r90_pkg::S_DIV: begin
                if (i_status.div_done) n_state = nv21r90_pkg::S_ADDR;
            end
            nv21r90_pkg::S_ADDR: n_state = nv21r90_pkg::S_RD0;
            nv21r90_pkg::S_RD0:  n_state = nv21r90_pkg::S_RD1;
            nv21r90_pkg::S_RD1:  n_state = nv21r90_pkg::S_MUL;
            nv21r90_pkg::S_MUL:  n_state = nv21r90_pkg::S_SUM;
            nv21r90_pkg::S_SUM: begin
                if (i_status.out_free) n_state = nv21r90_pkg::S_IDLE;
            end
            nv21r90_pkg::S_NRDY: begin
                if (i_status.out_free) n_state = nv21r90_pkg::S_IDLE;
            end
            default: n_state = nv21r90_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = take && (i_action == nv21r90_pkg::ACT_LOAD);
        o_cmd.fetch     = take && (i_action == nv21r90_pkg::ACT_FETCH);
        o_cmd.div_start = o_cmd.fetch && i_status.ready && i_status.need_div;
        o_cmd.div_take  = (r_state == nv21r90_pkg::S_DIV) && i_status.div_done;
        o_cmd.addr      = (r_state == nv21r90_pkg::S_ADDR);
        o_cmd.rd1       = (r_state == nv21r90_pkg::S_RD1);
        o_cmd.mul       = (r_state == nv21r90_pkg::S_MUL);
        o_cmd.emit_pix  = (r_state == nv21r90_pkg::S_SUM) && i_status.out_free;
        o_cmd.emit_nrdy = (r_state == nv21r90_pkg::S_NRDY) && i_status.out_free;
        o_in_stall      = (r_state != nv21r90_pkg::S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nv21r90_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_PROP(a_one_action, i_clk, i_rst_n,
        $onehot0({o_cmd.load, o_cmd.fetch, o_cmd.div_take, o_cmd.emit_pix, o_cmd.emit_nrdy}))
    `ASSERT_PROP(a_nrdy_path, i_clk, i_rst_n,
        (o_cmd.fetch && !i_status.ready) |=> (r_state == nv21r90_pkg::S_NRDY))
    `ASSERT_PROP(a_emit_to_idle, i_clk, i_rst_n,
        (o_cmd.emit_pix || o_cmd.emit_nrdy) |=> (r_state == nv21r90_pkg::S_IDLE))

endmodule

@@ bench/nv21_rotate90_to_argb_tb.sv @@
// Testbench for nv21_rotate90_to_argb: random NV21 frames, rotated ARGB readout checked per pixel.
`timescale 1ns / 1ps

module nv21_rotate90_to_argb_tb;
    import nv21r90_pkg::*;

    localparam int unsigned STORE_BYTES = MAX_WIDTH_DEF * MAX_HEIGHT_DEF * 3 / 2;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam longint unsigned LIMIT_NS = 64'd20_000_000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DIM_W-1:0]     i_cfg_wdata;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;

    // Mirrors the frame buffer and readout counters, keeps the pixels still owed.
    class pixel_scoreboard;
        t_out_item       pending[$];
        logic [7:0]      store[STORE_BYTES];
        logic [DIM_W-1:0] width_reg;
        logic [DIM_W-1:0] height_reg;
        int unsigned     bytes_in;
        int unsigned     pix_out;
        int unsigned     written_hi;
        bit              complete;
        bit              wrapped;
        int unsigned     errors;

        function new();
            width_reg  = FRAME_DIM_RST;
            height_reg = FRAME_DIM_RST;
            bytes_in   = 0;
            pix_out    = 0;
            written_hi = 0;
            complete   = 1'b0;
            wrapped    = 1'b0;
            errors     = 0;
        endfunction

        function int unsigned even_dim(logic [DIM_W-1:0] r, int unsigned cap);
            int unsigned d;
            d = {r[DIM_W-1:1], 1'b0};
            if (d < 2) d = 2;
            if (d > (cap & ~32'd1)) d = cap & ~32'd1;
            return d;
        endfunction

        function int unsigned bytes_for(logic [DIM_W-1:0] w_raw, logic [DIM_W-1:0] h_raw);
            int unsigned n;
            n = even_dim(w_raw, MAX_WIDTH_DEF) * even_dim(h_raw, MAX_HEIGHT_DEF);
            return n + n / 2;
        endfunction

        function bit is_ready();
            return complete || bytes_in >= bytes_for(width_reg, height_reg);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
            if (idx == CFG_FRAME_WIDTH) width_reg = val;
            else height_reg = val;
        endfunction

        function logic [17:0] sat18(int s);
            if (s < 0) return '0;
            if (s > 262143) return 18'h3FFFF;
            return s[17:0];
        endfunction

        function logic [ARGB_W-1:0] shade(logic [7:0] y, logic [7:0] v, logic [7:0] u);
            int luma, cr, cb;
            logic [17:0] r, g, b;
            luma = (y < 8'd16) ? 0 : int'(y) - 16;
            cr   = int'(v) - 128;
            cb   = int'(u) - 128;
            r = sat18(1192 * luma + 1634 * cr);
            g = sat18(1192 * luma - 833 * cr - 400 * cb);
            b = sat18(1192 * luma + 2066 * cb);
            return {ALPHA_OPAQUE, r[17:10], g[17:10], b[17:10]};
        endfunction

        // Returns 1 when the request did something (a load that was not dropped, or a fetch).
        function bit take_request(t_in_item req);
            int unsigned w, h, npix, nbytes, p, col, row, ya, ca;
            t_out_item res;
            w      = even_dim(width_reg, MAX_WIDTH_DEF);
            h      = even_dim(height_reg, MAX_HEIGHT_DEF);
            npix   = w * h;
            nbytes = npix + npix / 2;
            wrapped = 1'b0;
            if (req.action == ACT_LOAD) begin
                if (is_ready()) return 1'b0;
                store[bytes_in] = req.data_byte;
                bytes_in++;
                if (bytes_in > written_hi) written_hi = bytes_in;
                if (bytes_in >= nbytes) complete = 1'b1;
                return 1'b1;
            end
            res.argb       = '0;
            res.last_pixel = 1'b0;
            res.not_ready  = 1'b1;
            if (!is_ready()) begin
                pending.push_back(res);
                return 1'b1;
            end
            p = pix_out;
            // clamp the index when the geometry shrank under the readout
            if (p >= npix - 1) begin
                p = npix - 1;
                wrapped = 1'b1;
            end
            col = p % h;
            row = p / h;
            ya  = (h - 1 - col) * w + row;
            ca  = npix + (h / 2 - 1 - col / 2) * w + (row & ~32'd1);
            res.argb       = shade(store[ya], store[ca], store[ca + 1]);
            res.last_pixel = wrapped;
            res.not_ready  = 1'b0;
            pending.push_back(res);
            if (wrapped) begin
                pix_out  = 0;
                bytes_in = 0;
                complete = 1'b0;
            end else begin
                pix_out = p + 1;
            end
            return 1'b1;
        endfunction

        function void check_pixel(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                $display("%0t: pixel result with none expected, got %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.argb !== want.argb) begin
                $display("%0t: argb expected %08h, got %08h", $time, want.argb, got.argb);
                errors++;
            end
            if (got.last_pixel !== want.last_pixel) begin
                $display("%0t: last_pixel expected %b, got %b", $time,
                         want.last_pixel, got.last_pixel);
                errors++;
            end
            if (got.not_ready !== want.not_ready) begin
                $display("%0t: not_ready expected %b, got %b", $time,
                         want.not_ready, got.not_ready);
                errors++;
            end
        endfunction
    endclass

    pixel_scoreboard sb;
    bit              idle_on = 1'b1;
    int unsigned     items_done = 0;
    int unsigned     stall_left = 0;

    nv21_rotate90_to_argb uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Output backpressure in bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left  <= $urandom_range(1, 11) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Signals are stable between negedge and the next posedge, where the transfer happens
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_pixel(o_out_data);
    end

    task automatic send(input logic act, input logic [7:0] b);
        t_in_item req;
        req.action    = act;
        req.data_byte = b;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
        if (sb.take_request(req)) items_done++;
    endtask

    task automatic load_run(input int unsigned n);
        repeat (n) send(ACT_LOAD, 8'($urandom));
    endtask

    task automatic fetch_run(input int unsigned n);
        repeat (n) send(ACT_FETCH, 8'($urandom));
    endtask

    // Hold requests until every owed pixel is out and the datapath is quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [DIM_W-1:0] w_raw, input logic [DIM_W-1:0] h_raw);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_FRAME_WIDTH;
        i_cfg_wdata <= w_raw;
        @(posedge i_clk);
        sb.write_reg(CFG_FRAME_WIDTH, w_raw);
        i_cfg_idx   <= CFG_FRAME_HEIGHT;
        i_cfg_wdata <= h_raw;
        @(posedge i_clk);
        sb.write_reg(CFG_FRAME_HEIGHT, h_raw);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [DIM_W-1:0] pick_dim();
        if ($urandom_range(0, 11) == 0) return DIM_W'($urandom_range(14, 25));
        return DIM_W'($urandom_range(0, 13));
    endfunction

    // Load and read out until the frame wraps, with stray requests mixed in
    task automatic random_frame(input bit allow_reshape);
        int unsigned steps, reshape_at;
        logic [DIM_W-1:0] w_raw, h_raw;
        bit done;
        steps = 1;
        done  = 1'b0;
        reshape_at = 0;
        if (allow_reshape && $urandom_range(0, 4) == 0)
            reshape_at = $urandom_range(1, sb.bytes_for(sb.width_reg, sb.height_reg) * 5 / 3);
        while (!done) begin
            if (steps == reshape_at) begin
                // never let a finished frame grow past what was ever written
                do begin
                    w_raw = pick_dim();
                    h_raw = pick_dim();
                end while (sb.complete && sb.bytes_for(w_raw, h_raw) > sb.written_hi);
                set_geometry(w_raw, h_raw);
            end
            if (!sb.is_ready()) begin
                if ($urandom_range(0, 39) == 0) send(ACT_FETCH, 8'($urandom));
                else send(ACT_LOAD, 8'($urandom));
            end else if ($urandom_range(0, 39) == 0) begin
                send(ACT_LOAD, 8'($urandom));
            end else begin
                send(ACT_FETCH, 8'($urandom));
                done = sb.wrapped;
            end
            steps++;
        end
    endtask

    initial begin : stimulus
        int unsigned k;
        sb          = new();
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_FRAME_WIDTH;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry, nothing loaded
        send(ACT_FETCH, 8'hFF);
        set_geometry(10'd0, 10'd1);
        send(ACT_LOAD, 8'd0);
        send(ACT_LOAD, 8'd255);
        send(ACT_LOAD, 8'd16);
        send(ACT_FETCH, 8'h00);
        send(ACT_LOAD, 8'd15);
        send(ACT_LOAD, 8'd255);
        send(ACT_LOAD, 8'd0);
        send(ACT_LOAD, 8'hAA);  // frame already full: dropped
        fetch_run(4);
        send(ACT_LOAD, 8'd255);
        send(ACT_LOAD, 8'd0);
        send(ACT_LOAD, 8'd255);
        send(ACT_LOAD, 8'd0);
        send(ACT_LOAD, 8'd0);
        send(ACT_LOAD, 8'd255);
        fetch_run(4);

        // shrink while loading
        set_geometry(10'd4, 10'd5);
        load_run(10);
        set_geometry(10'd2, 10'd2);
        fetch_run(4);
        // shrink during readout
        set_geometry(10'd4, 10'd4);
        load_run(24);
        fetch_run(5);
        set_geometry(10'd3, 10'd3);
        fetch_run(1);
        // grow during readout, inside what was written
        set_geometry(10'd2, 10'd2);
        load_run(6);
        fetch_run(2);
        set_geometry(10'd4, 10'd2);
        random_frame(1'b0);

        // widest and tallest frames
        set_geometry(10'd1023, 10'd0);
        random_frame(1'b0);
        set_geometry(10'd1, 10'd512);
        random_frame(1'b0);

        items_done = 0;
        while (items_done < 1200) begin
            idle_on = (items_done < 1000) && ($urandom_range(0, 3) != 0);
            set_geometry(pick_dim(), pick_dim());
            random_frame(1'b1);
        end

        idle_on = 1'b0;
        i_in_valid <= 1'b0;
        for (k = 0; k < 5000 && sb.pending.size() != 0; k++) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.pending.size() != 0)
            $display("%0t: %0d pixel results never arrived", $time, sb.pending.size());
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule
